// ----- design/chad_pkg.sv -----
// Shared constants, phase codes and event codes for the archive decoder.
`default_nettype none
package chad_pkg;
    localparam int MAX_SYMBOLS_DEF  = 512;
    localparam int MAX_CODE_LEN_DEF = 32;
    localparam int FIELD_BITS       = 9;

    localparam logic [2:0] PH_COUNT   = 3'd0;
    localparam logic [2:0] PH_SYMBOLS = 3'd1;
    localparam logic [2:0] PH_LENGTHS = 3'd2;
    localparam logic [2:0] PH_NAME    = 3'd3;
    localparam logic [2:0] PH_CONTENT = 3'd4;
    localparam logic [2:0] PH_DONE    = 3'd5;
    localparam logic [2:0] PH_ERROR   = 3'd6;

    localparam logic [2:0] EV_NAME_BYTE    = 3'd0;
    localparam logic [2:0] EV_NAME_END     = 3'd1;
    localparam logic [2:0] EV_CONTENT_BYTE = 3'd2;
    localparam logic [2:0] EV_FILE_END     = 3'd3;
    localparam logic [2:0] EV_ARCHIVE_END  = 3'd4;
    localparam logic [2:0] EV_ERROR        = 3'd5;

    localparam logic [8:0] SYM_NAME_END    = 9'd256;
    localparam logic [8:0] SYM_FILE_END    = 9'd257;
    localparam logic [8:0] SYM_ARCHIVE_END = 9'd258;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] value;
        logic       last;
    } event_t;
endpackage
`default_nettype wire

// ----- design/canonical_huffman_archive_decoder_unit.sv -----
// Top level of the canonical code archive decoder: bit sequencer over two table RAMs.
// Steps: a header bit is handled in ST_BIT; a code bit passes ST_BIT then ST_CNT (count
// read), plus ST_SYM (symbol read) when it ends a code; an event word waits for the next
// event or the end of its byte. A new byte is taken only in idle with no event word held,
// once the last one is through; reset clears the sequencer and output register (aresetn,
// sync), table RAM contents are undefined until a header writes them.
`default_nettype none
module canonical_huffman_archive_decoder_unit
    import chad_pkg::*;
#(
    parameter int MAX_SYMBOLS  = MAX_SYMBOLS_DEF,
    parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_archive_byte,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [2:0]      m_event_kind,
    output logic [7:0]      m_byte_value,
    output logic            m_last
);
    localparam int SAW = $clog2(MAX_SYMBOLS);
    localparam int LW  = $clog2(MAX_CODE_LEN + 1);
    // First codes of an oversubscribed header grow by up to the symbol count bits.
    localparam int CW  = (MAX_CODE_LEN + 10 > 64) ? 64 : MAX_CODE_LEN + 10;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_BIT  = 2'd1;
    localparam logic [1:0] ST_CNT  = 2'd2;
    localparam logic [1:0] ST_SYM  = 2'd3;

    logic [1:0]     st_reg, st_next;
    logic [7:0]     byte_reg, byte_next;
    logic [2:0]     bit_reg, bit_next;
    logic [2:0]     phase_reg, phase_next;
    logic [3:0]     fcnt_reg, fcnt_next;
    logic [8:0]     fshift_reg, fshift_next;
    logic [9:0]     total_reg, total_next;
    logic [9:0]     entries_reg, entries_next;
    logic [9:0]     lsum_reg, lsum_next;
    logic [LW-1:0]  lidx_reg, lidx_next;
    logic [CW-1:0]  code_reg, code_next;
    logic [CW-1:0]  first_reg, first_next;
    logic [9:0]     ibase_reg, ibase_next;
    logic [LW-1:0]  clen_reg, clen_next;
    logic           pend_reg, pend_next;
    event_t         pev_reg, pev_next;

    logic           sym_we, cnt_we;
    logic [SAW-1:0] sym_addr;
    logic [8:0]     sym_wdata, sym_rdata, cnt_rdata;
    logic [LW-1:0]  cnt_addr;
    logic [8:0]     cnt_wdata;

    logic           q_ready, q_valid;
    event_t         q_event, m_event;

    logic           cur_bit, last_bit;
    logic [9:0]     fval;
    logic [CW-1:0]  offset;
    logic [9:0]     sidx;

    chad_ram #(.WIDTH(9), .DEPTH(1 << SAW)) u_sym_ram (
        .aclk(aclk), .we(sym_we), .addr(sym_addr), .wdata(sym_wdata), .rdata(sym_rdata)
    );
    chad_ram #(.WIDTH(9), .DEPTH(1 << LW)) u_cnt_ram (
        .aclk(aclk), .we(cnt_we), .addr(cnt_addr), .wdata(cnt_wdata), .rdata(cnt_rdata)
    );
    chad_out_reg u_out (
        .aclk(aclk), .aresetn(aresetn), .in_valid(q_valid), .in_ready(q_ready),
        .in_event(q_event), .m_valid(m_valid), .m_ready(m_ready), .m_event(m_event)
    );

    assign m_event_kind = m_event.kind;
    assign m_byte_value = m_event.value;
    assign m_last       = m_event.last;

    assign s_ready  = (st_reg == ST_IDLE) && !pend_reg;
    assign cur_bit  = byte_reg[bit_reg];
    assign last_bit = (bit_reg == 3'd0);
    assign fval     = {1'b0, cur_bit, fshift_reg[8:1]};
    assign offset   = code_reg - first_reg;
    assign sidx     = ibase_reg + offset[9:0];

    always_comb begin
        st_next = st_reg; byte_next = byte_reg; bit_next = bit_reg;
        phase_next = phase_reg; fcnt_next = fcnt_reg; fshift_next = fshift_reg;
        total_next = total_reg; entries_next = entries_reg; lsum_next = lsum_reg;
        lidx_next = lidx_reg; code_next = code_reg; first_next = first_reg;
        ibase_next = ibase_reg; clen_next = clen_reg;
        pend_next = pend_reg; pev_next = pev_reg;
        sym_we = 1'b0; sym_addr = sidx[SAW-1:0]; sym_wdata = fval[8:0];
        cnt_we = 1'b0; cnt_addr = clen_reg + LW'(1); cnt_wdata = fval[8:0];
        q_valid = 1'b0; q_event = pev_reg;

        case (st_reg)
            ST_IDLE: begin
                // Byte done: the held word now carries its final last flag.
                if (pend_reg && q_ready) begin
                    pend_next = 1'b0;
                    q_valid   = 1'b1;
                end
                if (s_valid && s_ready) begin
                    byte_next = s_archive_byte;
                    bit_next  = 3'd7;
                    st_next   = (phase_reg == PH_DONE || phase_reg == PH_ERROR) ?
                                ST_IDLE : ST_BIT;
                end
            end
            ST_BIT: begin
                if (!pend_reg || q_ready) begin
                    if (phase_reg <= PH_LENGTHS) begin
                        // Fields arrive least significant bit first.
                        fshift_next = {cur_bit, fshift_reg[8:1]};
                        fcnt_next   = fcnt_reg + 4'd1;
                        if (fcnt_reg == 4'(FIELD_BITS - 1)) begin
                            fshift_next = '0;
                            fcnt_next   = '0;
                            case (phase_reg)
                                PH_COUNT: begin
                                    if (fval == '0 || fval > 10'(MAX_SYMBOLS)) begin
                                        q_valid    = pend_reg;
                                        phase_next = PH_ERROR;
                                        pev_next   = '{EV_ERROR, 8'd0, 1'b0};
                                        pend_next  = 1'b1;
                                    end else begin
                                        total_next   = fval;
                                        entries_next = '0;
                                        phase_next   = PH_SYMBOLS;
                                    end
                                end
                                PH_SYMBOLS: begin
                                    sym_we       = entries_reg < 10'(MAX_SYMBOLS);
                                    sym_addr     = entries_reg[SAW-1:0];
                                    entries_next = entries_reg + 10'd1;
                                    if (entries_reg + 10'd1 >= total_reg) begin
                                        lsum_next  = '0;
                                        lidx_next  = '0;
                                        phase_next = PH_LENGTHS;
                                    end
                                end
                                default: begin
                                    lidx_next = lidx_reg + LW'(1);
                                    if (lidx_reg >= LW'(MAX_CODE_LEN) ||
                                        fval > total_reg - lsum_reg) begin
                                        q_valid    = pend_reg;
                                        phase_next = PH_ERROR;
                                        pev_next   = '{EV_ERROR, 8'd0, 1'b0};
                                        pend_next  = 1'b1;
                                    end else begin
                                        cnt_we    = 1'b1;
                                        cnt_addr  = lidx_reg + LW'(1);
                                        lsum_next = lsum_reg + fval;
                                        if (lsum_reg + fval == total_reg) begin
                                            code_next  = '0;
                                            first_next = '0;
                                            ibase_next = '0;
                                            clen_next  = '0;
                                            phase_next = PH_NAME;
                                        end
                                    end
                                end
                            endcase
                        end
                        bit_next = bit_reg - 3'd1;
                        if (last_bit || phase_next == PH_ERROR) begin
                            st_next = ST_IDLE;
                        end
                        if (last_bit || phase_next == PH_ERROR) begin
                            pev_next.last = 1'b1;
                        end
                    end else begin
                        code_next = code_reg | CW'(cur_bit);
                        clen_next = clen_reg + LW'(1);
                        if (clen_reg >= lidx_reg) begin
                            q_valid    = pend_reg;
                            phase_next = PH_ERROR;
                            pev_next   = '{EV_ERROR, 8'd0, 1'b1};
                            pend_next  = 1'b1;
                            st_next    = ST_IDLE;
                        end else begin
                            cnt_addr = clen_reg + LW'(1);
                            st_next  = ST_CNT;
                        end
                    end
                end
            end
            ST_CNT: begin
                // Hold the count word on the RAM output while stalled.
                cnt_addr = clen_reg;
                if (code_reg >= first_reg && offset < CW'(cnt_rdata)) begin
                    st_next = ST_SYM;
                end else if (clen_reg < lidx_reg || !pend_reg || q_ready) begin
                    ibase_next = ibase_reg + 10'(cnt_rdata);
                    first_next = (first_reg + CW'(cnt_rdata)) << 1;
                    code_next  = code_reg << 1;
                    bit_next   = bit_reg - 3'd1;
                    if (clen_reg >= lidx_reg) begin
                        q_valid    = pend_reg;
                        phase_next = PH_ERROR;
                        pev_next   = '{EV_ERROR, 8'd0, 1'b1};
                        pend_next  = 1'b1;
                        st_next    = ST_IDLE;
                    end else begin
                        st_next = last_bit ? ST_IDLE : ST_BIT;
                        if (last_bit && pend_reg) begin
                            pev_next.last = 1'b1;
                        end
                    end
                end
            end
            default: begin
                // Symbol word is on the RAM output; classify it.
                if (!pend_reg || q_ready) begin
                    q_valid    = pend_reg;
                    code_next  = '0;
                    first_next = '0;
                    ibase_next = '0;
                    clen_next  = '0;
                    bit_next   = bit_reg - 3'd1;
                    pend_next  = 1'b1;
                    pev_next   = '{EV_ERROR, 8'd0, 1'b0};
                    if (phase_reg == PH_NAME) begin
                        if (sym_rdata < SYM_NAME_END) begin
                            pev_next = '{EV_NAME_BYTE, sym_rdata[7:0], 1'b0};
                        end else if (sym_rdata == SYM_NAME_END) begin
                            pev_next   = '{EV_NAME_END, 8'd0, 1'b0};
                            phase_next = PH_CONTENT;
                        end else begin
                            phase_next = PH_ERROR;
                        end
                    end else begin
                        if (sym_rdata < SYM_NAME_END) begin
                            pev_next = '{EV_CONTENT_BYTE, sym_rdata[7:0], 1'b0};
                        end else if (sym_rdata == SYM_FILE_END) begin
                            pev_next    = '{EV_FILE_END, 8'd0, 1'b0};
                            fshift_next = '0;
                            fcnt_next   = '0;
                            phase_next  = PH_COUNT;
                        end else if (sym_rdata == SYM_ARCHIVE_END) begin
                            pev_next   = '{EV_ARCHIVE_END, 8'd0, 1'b0};
                            phase_next = PH_DONE;
                        end else begin
                            phase_next = PH_ERROR;
                        end
                    end
                    if (last_bit || phase_next == PH_DONE || phase_next == PH_ERROR) begin
                        pev_next.last = 1'b1;
                        st_next       = ST_IDLE;
                    end else begin
                        st_next = ST_BIT;
                    end
                    if (sidx >= 10'(MAX_SYMBOLS)) begin
                        // Out-of-table index reads as symbol zero.
                        pev_next.value = 8'd0;
                        if (phase_reg == PH_NAME) begin
                            pev_next.kind = EV_NAME_BYTE;
                        end else begin
                            pev_next.kind = EV_CONTENT_BYTE;
                        end
                        phase_next = phase_reg;
                        if (!last_bit) begin
                            pev_next.last = 1'b0;
                            st_next       = ST_BIT;
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE; phase_reg <= PH_COUNT; fcnt_reg <= '0; fshift_reg <= '0;
            total_reg <= '0; entries_reg <= '0; lsum_reg <= '0; lidx_reg <= '0;
            code_reg <= '0; first_reg <= '0; ibase_reg <= '0; clen_reg <= '0;
            pend_reg <= 1'b0; bit_reg <= '0;
        end else begin
            st_reg <= st_next; phase_reg <= phase_next; fcnt_reg <= fcnt_next;
            fshift_reg <= fshift_next; total_reg <= total_next;
            entries_reg <= entries_next; lsum_reg <= lsum_next; lidx_reg <= lidx_next;
            code_reg <= code_next; first_reg <= first_next; ibase_reg <= ibase_next;
            clen_reg <= clen_next; pend_reg <= pend_next; bit_reg <= bit_next;
        end
        byte_reg <= byte_next;
        pev_reg  <= pev_next;
    end

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |-> st_reg == ST_IDLE) else $error("byte taken while busy");
    a_sym_after_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg == ST_SYM |-> $past(st_reg) == ST_CNT || $past(st_reg) == ST_SYM)
        else $error("symbol read out of order");
    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_event_kind <= EV_ERROR) else $error("bad event kind");
endmodule
`default_nettype wire

// ----- design/chad_ram.sv -----
// Generic single-port synchronous RAM with a registered read.
`default_nettype none
module chad_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 512
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// ----- design/chad_out_reg.sv -----
// One-entry output register that holds an event word until it is taken.
`default_nettype none
module chad_out_reg
    import chad_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   in_valid,
    output logic        in_ready,
    input  wire event_t in_event,
    output logic        m_valid,
    input  wire logic   m_ready,
    output event_t      m_event
);
    logic   valid_reg;
    event_t event_reg;

    assign in_ready = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_event  = event_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            event_reg <= in_event;
        end
    end
endmodule
`default_nettype wire
